// ===== rtl/f2iq_pkg.sv =====
// Shared types and constants for the float32 to int8 quantiser pipeline.
package f2iq_pkg;

  localparam int unsigned FP_BIAS = 127;
  // Offset from the product of two 24-bit significands back to a real scale.
  localparam logic signed [10:0] PROD_EXP_OFS = 11'sd300;

  typedef enum logic {
    REG_INV_SCALE   = 1'b0,
    REG_ZERO_OFFSET = 1'b1
  } f2iq_reg_t;

  typedef struct packed {
    logic sign;
    logic nan;
    logic inf;
    logic last;
  } f2iq_flags_t;

  // After the significand multiply.
  typedef struct packed {
    f2iq_flags_t        flags;
    logic [47:0]        prod;
    logic signed [10:0] exp;
  } f2iq_s1_t;

  // After normalisation: leading one at bit 47, q is the weight of that bit.
  typedef struct packed {
    f2iq_flags_t        flags;
    logic               zero;
    logic [47:0]        norm;
    logic signed [10:0] q;
  } f2iq_s2_t;

  // After rounding to float32: magnitude plus one half, 25 fraction bits.
  typedef struct packed {
    f2iq_flags_t flags;
    logic        sat;
    logic        tiny;
    logic [33:0] w;
  } f2iq_s3_t;

endpackage

// ===== rtl/f2iq_mul.sv =====
// Stage one: unpacks both operands, flags special values, multiplies significands.
module f2iq_mul (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [31:0]           sample_bits,
  input  logic                  last_in,
  input  logic [31:0]           inv_scale,
  output logic                  valid,
  output f2iq_pkg::f2iq_s1_t    data
);
  import f2iq_pkg::*;

  logic [7:0]  ea, eb, ea_eff, eb_eff;
  logic [22:0] fa, fb;
  logic [23:0] ma, mb;
  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, nan;
  f2iq_s1_t    data_next;

  always_comb begin
    ea = sample_bits[30:23];
    fa = sample_bits[22:0];
    eb = inv_scale[30:23];
    fb = inv_scale[22:0];
    ma = {ea != 8'd0, fa};
    mb = {eb != 8'd0, fb};
    ea_eff = (ea == 8'd0) ? 8'd1 : ea;
    eb_eff = (eb == 8'd0) ? 8'd1 : eb;
    nan_a  = (ea == 8'hFF) && (fa != 23'd0);
    nan_b  = (eb == 8'hFF) && (fb != 23'd0);
    inf_a  = (ea == 8'hFF) && (fa == 23'd0);
    inf_b  = (eb == 8'hFF) && (fb == 23'd0);
    zero_a = (ea == 8'd0) && (fa == 23'd0);
    zero_b = (eb == 8'd0) && (fb == 23'd0);
    nan    = nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a);

    data_next.flags.sign = sample_bits[31] ^ inv_scale[31];
    data_next.flags.nan  = nan;
    data_next.flags.inf  = (inf_a || inf_b) && !nan;
    data_next.flags.last = last_in;
    data_next.prod       = ma * mb;
    data_next.exp        = $signed({3'b000, ea_eff}) + $signed({3'b000, eb_eff})
                           - PROD_EXP_OFS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= data_next;
    end
  end

endmodule

// ===== rtl/f2iq_norm.sv =====
// Stage two: leading-one search and left shift of the raw product.
module f2iq_norm (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  f2iq_pkg::f2iq_s1_t    in_data,
  output logic                  valid,
  output f2iq_pkg::f2iq_s2_t    data
);
  import f2iq_pkg::*;

  logic [5:0] lead;
  f2iq_s2_t   data_next;

  always_comb begin
    lead = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (in_data.prod[i]) begin
        lead = 6'(i);
      end
    end
    data_next.flags = in_data.flags;
    data_next.zero  = (in_data.prod == 48'd0);
    data_next.norm  = in_data.prod << (6'd47 - lead);
    data_next.q     = in_data.exp + $signed({5'b00000, lead});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= data_next;
    end
  end

endmodule

// ===== rtl/f2iq_round.sv =====
// Stage three: rounds the product to float32 and adds one half in fixed point.
module f2iq_round (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  f2iq_pkg::f2iq_s2_t    in_data,
  output logic                  valid,
  output f2iq_pkg::f2iq_s3_t    data
);
  import f2iq_pkg::*;

  logic [23:0]        mant, mant_r;
  logic [24:0]        mant_sum;
  logic               guard, sticky, up;
  logic signed [10:0] q_r;
  logic [3:0]         sh;
  logic [32:0]        fixed;
  f2iq_s3_t           data_next;

  always_comb begin
    mant     = in_data.norm[47:24];
    guard    = in_data.norm[23];
    sticky   = |in_data.norm[22:0];
    up       = guard && (sticky || mant[0]);
    mant_sum = {1'b0, mant} + {24'd0, up};
    mant_r   = mant_sum[24] ? mant_sum[24:1] : mant_sum[23:0];
    q_r      = in_data.q + $signed({10'd0, mant_sum[24]});
    // below a quarter the sum with one half cannot reach one
    data_next.tiny  = in_data.zero || (in_data.q < -11'sd2);
    data_next.sat   = !data_next.tiny && (q_r > 11'sd7);
    sh              = 4'(q_r + 11'sd2);
    fixed           = {9'd0, mant_r} << sh;
    data_next.w     = {1'b0, fixed} + (34'd1 << 24);
    data_next.flags = in_data.flags;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= data_next;
    end
  end

endmodule

// ===== rtl/f2iq_out.sv =====
// Stage four: float32 rounding of the half-adjusted sum, truncation, offset, clamp.
module f2iq_out (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  f2iq_pkg::f2iq_s3_t    in_data,
  input  logic signed [7:0]     zero_offset,
  output logic                  valid,
  output logic signed [7:0]     quantized,
  output logic                  last_out
);
  import f2iq_pkg::*;

  logic [5:0]         lead;
  logic [3:0]         k;
  logic [33:0]        below;
  logic               guard, sticky, lsb, up;
  logic [34:0]        wr;
  logic [9:0]         t;
  logic signed [10:0] tv, sum;
  logic signed [7:0]  q_next;

  always_comb begin
    lead = 6'd24;
    for (int i = 24; i < 34; i++) begin
      if (in_data.w[i]) begin
        lead = 6'(i);
      end
    end
    // 24 significant bits kept, so the lowest kept bit is lead - 23
    k      = 4'(lead - 6'd23);
    below  = (34'd1 << (k - 4'd1)) - 34'd1;
    guard  = in_data.w[6'(k) - 6'd1];
    lsb    = in_data.w[6'(k)];
    sticky = |(in_data.w & below);
    up     = guard && (sticky || lsb);
    wr     = (({1'b0, in_data.w} >> k) + {34'd0, up}) << k;
    t      = in_data.tiny ? 10'd0 : wr[34:25];
    tv     = in_data.flags.sign ? -$signed({1'b0, t}) : $signed({1'b0, t});
    sum    = tv + $signed({{3{zero_offset[7]}}, zero_offset});

    priority if (in_data.flags.nan) begin
      q_next = zero_offset;
    end else if (in_data.flags.inf || in_data.sat) begin
      q_next = in_data.flags.sign ? -8'sd128 : 8'sd127;
    end else if (sum > 11'sd127) begin
      q_next = 8'sd127;
    end else if (sum < -11'sd128) begin
      q_next = -8'sd128;
    end else begin
      q_next = sum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quantized <= q_next;
      last_out  <= in_data.flags.last;
    end
  end

endmodule

// ===== rtl/float_to_int8_quantizer_core.sv =====
// Top level of the float32 to int8 quantiser: config registers and four-stage pipeline.
//
//   channel   handshake                     payload
//   sample    sample_valid / sample_stall   sample_bits, last_in
//   result    result_valid / result_stall   quantized, last_out
//   config    cfg_write                     cfg_index, cfg_data
//
// Four register stages (multiply, normalise, round, output); one word per cycle is
// sustained while result_stall is low. Each stage holds its word while the next
// is full, so bubbles close up under a stall.
// The 24x24 significand multiply and the two float32 rounding steps set the stage split.
// rst clears the stage valid bits and loads a scale of 1.0 and zero offset 0.
module float_to_int8_quantizer_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  logic [31:0]       sample_bits,
  input  logic              last_in,
  output logic              result_valid,
  input  logic              result_stall,
  output logic signed [7:0] quantized,
  output logic              last_out,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data
);
  import f2iq_pkg::*;

  logic [31:0]       inv_scale;
  logic signed [7:0] zero_offset;
  logic              en1, en2, en3, en4;
  logic              v1, v2, v3;
  f2iq_s1_t          d1;
  f2iq_s2_t          d2;
  f2iq_s3_t          d3;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_scale   <= 32'h3F80_0000;
      zero_offset <= 8'sd0;
    end else if (cfg_write) begin
      unique case (f2iq_reg_t'(cfg_index))
        REG_INV_SCALE:   inv_scale   <= cfg_data;
        REG_ZERO_OFFSET: zero_offset <= cfg_data[7:0];
        default:         inv_scale   <= inv_scale;
      endcase
    end
  end

  assign en4          = !result_valid || !result_stall;
  assign en3          = !v3 || en4;
  assign en2          = !v2 || en3;
  assign en1          = !v1 || en2;
  assign sample_stall = !en1;

  f2iq_mul u_mul (
    .clk, .rst, .en(en1), .in_valid(sample_valid), .sample_bits, .last_in,
    .inv_scale, .valid(v1), .data(d1)
  );

  f2iq_norm u_norm (
    .clk, .rst, .en(en2), .in_valid(v1), .in_data(d1), .valid(v2), .data(d2)
  );

  f2iq_round u_round (
    .clk, .rst, .en(en3), .in_valid(v2), .in_data(d2), .valid(v3), .data(d3)
  );

  f2iq_out u_out (
    .clk, .rst, .en(en4), .in_valid(v3), .in_data(d3), .zero_offset,
    .valid(result_valid), .quantized, .last_out
  );

`ifndef SYNTHESIS
  // back-pressure only when every stage holds a word
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> (v1 && v2 && v3 && result_valid))
    else $error("input stalled with an empty stage");

  a_nan_offset: assert property (@(posedge clk) disable iff (rst)
    (v3 && en4 && d3.flags.nan) |=> (quantized == $past(zero_offset)))
    else $error("NaN word did not give the zero point");

  a_sat_sign: assert property (@(posedge clk) disable iff (rst)
    (v3 && en4 && !d3.flags.nan && (d3.sat || d3.flags.inf))
    |=> (quantized == ($past(d3.flags.sign) ? -8'sd128 : 8'sd127)))
    else $error("saturated word has wrong value");

  a_last_follow: assert property (@(posedge clk) disable iff (rst)
    (v3 && en4) |=> (result_valid && last_out == $past(d3.flags.last)))
    else $error("last flag lost in final stage");
`endif

endmodule
